>>> rtl/kvgrc_pkg.sv
// Shared types, constants and helpers for the key-value GET request classifier.
`default_nettype none

package kvgrc_pkg;

    // Fixed frame layout: 14-byte Ethernet header, 20-byte IPv4 header
    localparam logic [15:0] PROTO_POS         = 16'd23;
    localparam logic [15:0] DPORT_HI_POS      = 16'd36;
    localparam logic [15:0] DPORT_LO_POS      = 16'd37;
    localparam logic [15:0] TRANSPORT_START   = 16'd34;
    localparam logic [15:0] UDP_MIN_LEN       = 16'd42;
    localparam logic [15:0] TCP_PAYLOAD_START = 16'd54;
    localparam logic [15:0] MIN_PAYLOAD       = 16'd4;
    localparam logic [15:0] POS_MAX           = 16'hFFFF;

    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam logic [7:0] CHAR_G     = 8'h67;
    localparam logic [7:0] CHAR_E     = 8'h65;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Length of the "get " prefix
    localparam logic [2:0] PREFIX_LEN = 3'd4;
    // Scan offset right after the prefix
    localparam logic [10:0] KEY_START = 11'd4;

    // Register map, indexed by word address
    localparam logic REG_SERVICE_PORT   = 1'b0;
    localparam logic REG_MAX_KEY_OFFSET = 1'b1;

    localparam logic [15:0] SERVICE_PORT_RST   = 16'd11211;
    localparam logic [10:0] MAX_KEY_OFFSET_RST = 11'd1500;

    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_GET   = 2'd1,
        VERDICT_INVAL = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [15:0] service_port;
        logic [10:0] max_key_offset;
    } t_cfg;

    typedef struct packed {
        t_verdict    verdict;
        logic [10:0] key_offset;
        logic [31:0] packets_seen;
        logic [31:0] get_requests_seen;
    } t_result;

    // Expected character of the "get " prefix at a payload offset
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = CHAR_G;
            2'd1:    c = CHAR_E;
            2'd2:    c = CHAR_T;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kv_get_request_classifier.sv
// Top level of the key-value GET request classifier: handshake registers and wiring.
`default_nettype none

// Classifies Ethernet frames fed one byte per transaction. Each byte goes into
// an input register and is parsed as it leaves it; on the last byte of a
// frame one result (verdict, key offset, frame and GET counters) is loaded into
// the output register, which drives o_valid. One byte per cycle is sustained:
// the parser updates its small state as each byte moves on, and the input side
// stalls only when the output register is full, stalled, and the waiting byte
// ends a frame. Registers at byte address 0 (service port, reset 11211) and 4
// (key offset limit, reset 1500) are written through the APB port; the
// user must write them only while no frame is in flight, which the block
// does not enforce.
module kv_get_request_classifier
    import kvgrc_pkg::*;
#(
    parameter int UDP_FRAME_HEADER_BYTES = 8
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_verdict,
    output logic [10:0]      o_key_offset,
    output logic [31:0]      o_packets_seen,
    output logic [31:0]      o_get_requests_seen,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg    w_cfg;
    t_result w_result;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_adv;
    logic       w_accept;

    logic    r_out_valid;
    t_result r_out;

    kvgrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kvgrc_parse #(
        .UDP_FRAME_HEADER_BYTES (UDP_FRAME_HEADER_BYTES)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // A held byte moves on unless it ends a frame and the output slot is blocked
    assign w_adv    = r_in_valid && (!r_in_last || !r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_adv;
    assign w_accept = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_verdict           = r_out.verdict;
    assign o_key_offset        = r_out.key_offset;
    assign o_packets_seen      = r_out.packets_seen;
    assign o_get_requests_seen = r_out.get_requests_seen;

endmodule

`default_nettype wire

>>> rtl/kvgrc_cfg.sv
// APB-style register file holding the service port and the key offset limit.
`default_nettype none

module kvgrc_cfg
    import kvgrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [15:0] r_service_port;
    logic [10:0] r_max_key_offset;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_port   <= SERVICE_PORT_RST;
            r_max_key_offset <= MAX_KEY_OFFSET_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SERVICE_PORT:   r_service_port   <= pwdata[15:0];
                REG_MAX_KEY_OFFSET: r_max_key_offset <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[2])
            REG_SERVICE_PORT:   prdata = {16'd0, r_service_port};
            REG_MAX_KEY_OFFSET: prdata = {21'd0, r_max_key_offset};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg.service_port   = r_service_port;
    assign o_cfg.max_key_offset = r_max_key_offset;

endmodule

`default_nettype wire

>>> rtl/kvgrc_parse.sv
// Per-byte frame parser: header capture, "get " match, space scan and verdict.
`default_nettype none

module kvgrc_parse
    import kvgrc_pkg::*;
#(
    parameter int UDP_FRAME_HEADER_BYTES = 8
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    localparam int          UdpPayInt = 42 + UDP_FRAME_HEADER_BYTES;
    localparam logic [15:0] UDP_PAY   = 16'(UdpPayInt);
    localparam logic [15:0] UDP_PREFIX_END = 16'(UdpPayInt + 4);
    // Last byte position that still leaves at least four UDP payload bytes
    localparam logic [15:0] UDP_MIN_LAST   = 16'(UdpPayInt + 3);
    localparam logic [15:0] TCP_MIN_LAST   = TCP_PAYLOAD_START + MIN_PAYLOAD - 16'd1;
    localparam logic [15:0] IP_MIN_LAST    = TRANSPORT_START - 16'd1;

    logic [15:0] r_pos,    n_pos;
    logic [7:0]  r_proto,  n_proto;
    logic [15:0] r_dport,  n_dport;
    logic [2:0]  r_prefix, n_prefix;
    logic        r_active, n_active;
    logic [10:0] r_scan,   n_scan;
    logic [31:0] r_frames, n_frames;
    logic [31:0] r_gets,   n_gets;

    logic [15:0] w_p;
    logic        w_udp_zone;
    logic        w_get_hit;
    t_verdict    w_verdict;
    logic [10:0] w_koff;

    assign w_p = r_pos - UDP_PAY;

    always_comb begin
        n_pos     = r_pos;
        n_proto   = r_proto;
        n_dport   = r_dport;
        n_prefix  = r_prefix;
        n_active  = r_active;
        n_scan    = r_scan;
        n_frames  = r_frames;
        n_gets    = r_gets;
        w_get_hit = 1'b0;
        w_verdict = VERDICT_PASS;
        w_koff    = 11'd0;

        // Header field capture
        if (r_pos == PROTO_POS) begin
            n_proto = i_byte;
        end else if (r_pos == DPORT_HI_POS) begin
            n_dport[15:8] = i_byte;
        end else if (r_pos == DPORT_LO_POS) begin
            n_dport[7:0] = i_byte;
        end

        // UDP payload: prefix match, then skip extra spaces
        w_udp_zone = (n_proto == PROTO_UDP) && (r_pos >= UDP_PAY);
        if (w_udp_zone) begin
            if (r_pos < UDP_PREFIX_END) begin
                if (r_prefix == {1'b0, w_p[1:0]} && i_byte == get_char(w_p[1:0])) begin
                    n_prefix = r_prefix + 3'd1;
                    if (n_prefix == PREFIX_LEN) begin
                        n_scan   = KEY_START;
                        n_active = 1'b1;
                    end
                end
            end else if (r_active) begin
                if (r_scan < i_cfg.max_key_offset && i_byte == CHAR_SPACE) begin
                    n_scan = r_scan + 11'd1;
                end else begin
                    n_active = 1'b0;
                end
            end
        end

        if (!i_last) begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 16'd1;
            end
        end else begin
            // End of frame: one verdict, frame counter bumps (GET counter on a match), per-frame state clears
            n_frames = r_frames + 32'd1;
            if (r_pos >= IP_MIN_LAST && n_dport == i_cfg.service_port) begin
                if (n_proto == PROTO_UDP && r_pos >= UDP_MIN_LAST) begin
                    if (n_prefix == PREFIX_LEN) begin
                        w_get_hit = 1'b1;
                        if (n_scan < i_cfg.max_key_offset) begin
                            w_verdict = VERDICT_GET;
                            w_koff    = n_scan;
                        end
                    end
                end else if (n_proto == PROTO_TCP && r_pos >= TCP_MIN_LAST) begin
                    w_verdict = VERDICT_INVAL;
                end
            end
            if (w_get_hit) begin
                n_gets = r_gets + 32'd1;
            end
            n_pos    = 16'd0;
            n_proto  = 8'd0;
            n_dport  = 16'd0;
            n_prefix = 3'd0;
            n_active = 1'b0;
            n_scan   = 11'd0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 16'd0;
            r_proto  <= 8'd0;
            r_dport  <= 16'd0;
            r_prefix <= 3'd0;
            r_active <= 1'b0;
            r_scan   <= 11'd0;
            r_frames <= 32'd0;
            r_gets   <= 32'd0;
        end else if (i_adv) begin
            r_pos    <= n_pos;
            r_proto  <= n_proto;
            r_dport  <= n_dport;
            r_prefix <= n_prefix;
            r_active <= n_active;
            r_scan   <= n_scan;
            r_frames <= n_frames;
            r_gets   <= n_gets;
        end
    end

    assign o_result.verdict           = w_verdict;
    assign o_result.key_offset        = w_koff;
    assign o_result.packets_seen      = n_frames;
    assign o_result.get_requests_seen = n_gets;

endmodule

`default_nettype wire

>>> bench/kvgrc_checker.sv
// Checker for the GET request classifier: models the byte parser and compares every verdict.
`timescale 1ns / 100ps

module kvgrc_checker
    import kvgrc_pkg::*;
#(
    parameter int UDP_FRAME_HEADER_BYTES = 8
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_verdict,
    input  logic [10:0] i_key_offset,
    input  logic [31:0] i_packets_seen,
    input  logic [31:0] i_get_requests_seen,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending
);

    localparam int UDP_PAY = UDP_MIN_LEN + UDP_FRAME_HEADER_BYTES;
    // "get " packed low character first
    localparam logic [31:0] GET_PREFIX = {CHAR_SPACE, CHAR_T, CHAR_E, CHAR_G};

    // Configuration as last written over APB
    logic [15:0] cfg_port;
    logic [10:0] cfg_max_off;

    // Parser state of the frame in flight
    logic [15:0] byte_pos;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [2:0]  prefix_cnt;
    logic        skipping;
    logic [10:0] key_pos;
    logic [31:0] frame_cnt;
    logic [31:0] get_cnt;

    t_result verdict_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic clear_frame();
        byte_pos   = '0;
        proto      = '0;
        dport      = '0;
        prefix_cnt = '0;
        skipping   = 1'b0;
        key_pos    = '0;
    endtask

    task automatic note_failure(input string msg);
        o_errors++;
        if (o_errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Advance the parser by one byte; on the last byte queue the verdict
    task automatic classify_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned pay_idx;
        int unsigned len;
        t_result     r;
        pos = byte_pos;
        if (pos == PROTO_POS)
            proto = b;
        else if (pos == DPORT_HI_POS)
            dport[15:8] = b;
        else if (pos == DPORT_LO_POS)
            dport[7:0] = b;

        // prefix match, then skip extra spaces up to the limit
        if (proto == PROTO_UDP && pos >= UDP_PAY) begin
            pay_idx = pos - UDP_PAY;
            if (pay_idx < PREFIX_LEN) begin
                if (prefix_cnt == pay_idx && b == GET_PREFIX[8*pay_idx +: 8]) begin
                    prefix_cnt = prefix_cnt + 1'b1;
                    if (prefix_cnt == PREFIX_LEN) begin
                        key_pos  = KEY_START;
                        skipping = 1'b1;
                    end
                end
            end else if (skipping) begin
                if (key_pos < cfg_max_off && b == CHAR_SPACE)
                    key_pos = key_pos + 1'b1;
                else
                    skipping = 1'b0;
            end
        end

        if (!last) begin
            if (byte_pos != POS_MAX)
                byte_pos = byte_pos + 1'b1;
        end else begin
            len          = pos + 1;
            r.verdict    = VERDICT_PASS;
            r.key_offset = '0;
            frame_cnt    = frame_cnt + 1'b1;
            if (len >= TRANSPORT_START && dport == cfg_port) begin
                if (proto == PROTO_UDP && len >= UDP_PAY + MIN_PAYLOAD) begin
                    if (prefix_cnt == PREFIX_LEN) begin
                        get_cnt = get_cnt + 1'b1;
                        if (key_pos < cfg_max_off) begin
                            r.verdict    = VERDICT_GET;
                            r.key_offset = key_pos;
                        end
                    end
                end else if (proto == PROTO_TCP && len >= TCP_PAYLOAD_START + MIN_PAYLOAD) begin
                    r.verdict = VERDICT_INVAL;
                end
            end
            r.packets_seen      = frame_cnt;
            r.get_requests_seen = get_cnt;
            verdict_q.push_back(r);
            clear_frame();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_port    = SERVICE_PORT_RST;
            cfg_max_off = MAX_KEY_OFFSET_RST;
            frame_cnt   = '0;
            get_cnt     = '0;
            clear_frame();
            verdict_q.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MAX_KEY_OFFSET)
                    cfg_max_off = pwdata[10:0];
                else
                    cfg_port = pwdata[15:0];
            end

            // result transaction
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: verdict %0d offset %0d",
                                           i_verdict, i_key_offset));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_verdict !== want.verdict || i_key_offset !== want.key_offset ||
                        i_packets_seen !== want.packets_seen ||
                        i_get_requests_seen !== want.get_requests_seen)
                        note_failure($sformatf(
                            {"mismatch: verdict %0d/%0d offset %0d/%0d frames %0d/%0d ",
                             "gets %0d/%0d (expected/actual)"},
                            want.verdict, i_verdict, want.key_offset, i_key_offset,
                            want.packets_seen, i_packets_seen,
                            want.get_requests_seen, i_get_requests_seen));
                end
            end

            // byte transaction
            if (i_in_valid && !i_in_stall)
                classify_byte(i_frame_byte, i_last_byte);
        end
        o_pending = verdict_q.size();
    end

endmodule

>>> bench/tb_kv_get_request_classifier.sv
// Testbench top for the GET request classifier: frame stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_kv_get_request_classifier;
    import kvgrc_pkg::*;

    localparam int UDP_HDR_BYTES = 8;
    localparam int UDP_PAY       = UDP_MIN_LEN + UDP_HDR_BYTES;
    localparam int LONG_HOLD     = 400;
    localparam int LONG_FRAME    = 120;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_frame_byte = '0;
    logic        i_last_byte  = 1'b0;
    logic        i_stall      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;

    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_verdict;
    logic [10:0] o_key_offset;
    logic [31:0] o_packets_seen;
    logic [31:0] o_get_requests_seen;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;

    // stimulus controls
    logic        quiet    = 1'b0;
    logic        hold_req = 1'b0;
    logic [15:0] cur_port = SERVICE_PORT_RST;
    logic [10:0] cur_max  = MAX_KEY_OFFSET_RST;
    int          phase_bytes;
    logic [7:0]  frm[$];

    kv_get_request_classifier #(
        .UDP_FRAME_HEADER_BYTES(UDP_HDR_BYTES)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_frame_byte       (i_frame_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_verdict          (o_verdict),
        .o_key_offset       (o_key_offset),
        .o_packets_seen     (o_packets_seen),
        .o_get_requests_seen(o_get_requests_seen),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    kvgrc_checker #(
        .UDP_FRAME_HEADER_BYTES(UDP_HDR_BYTES)
    ) checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_frame_byte       (i_frame_byte),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_verdict          (o_verdict),
        .i_key_offset       (o_key_offset),
        .i_packets_seen     (o_packets_seen),
        .i_get_requests_seen(o_get_requests_seen),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // One byte transaction; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        phase_bytes++;
        @(negedge i_clk);
    endtask

    // Send len bytes of the built frame, padding with random bytes
    task automatic send_frame(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_byte((k < frm.size()) ? frm[k] : 8'($urandom_range(0, 255)), k == len - 1);
    endtask

    // Random Ethernet/IP/transport headers up to the UDP payload start
    task automatic start_frame(input logic [7:0] proto, input logic [15:0] port);
        int k;
        frm.delete();
        for (k = 0; k < UDP_PAY; k++)
            frm.push_back(8'($urandom_range(0, 255)));
        frm[PROTO_POS]    = proto;
        frm[DPORT_HI_POS] = port[15:8];
        frm[DPORT_LO_POS] = port[7:0];
    endtask

    // "get " + extra spaces + printable key
    task automatic push_get(input int nsp, input int keylen);
        frm.push_back(CHAR_G);
        frm.push_back(CHAR_E);
        frm.push_back(CHAR_T);
        frm.push_back(CHAR_SPACE);
        repeat (nsp) frm.push_back(CHAR_SPACE);
        repeat (keylen) frm.push_back(8'($urandom_range(8'h21, 8'h7e)));
    endtask

    task automatic push_noise(input int n);
        repeat (n) frm.push_back(8'($urandom_range(0, 255)));
    endtask

    // Drop valid and let all verdicts drain before touching registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_KEY_OFFSET)
            cur_max = val[10:0];
        else
            cur_port = val[15:0];
    endtask

    // Mostly well-formed requests to the service, some broken, some noise
    task automatic send_random_frame();
        int          pick;
        int          nsp;
        int          len;
        logic [7:0]  proto;
        logic [15:0] port;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            proto = PROTO_UDP;
        else if (pick < 80)
            proto = PROTO_TCP;
        else
            proto = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 7);
        if (pick < 6)
            port = cur_port;
        else if (pick == 6)
            port = cur_port ^ (16'd1 << $urandom_range(0, 15));
        else
            port = 16'($urandom_range(0, 65535));
        start_frame(proto, port);

        if (proto == PROTO_UDP) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                // occasionally run the space scan right up to the limit
                if ($urandom_range(0, (cur_max <= 64) ? 9 : 39) == 0) begin
                    nsp = int'(cur_max) - 7 + int'($urandom_range(0, 5));
                    if (nsp < 0)
                        nsp = 0;
                end else begin
                    nsp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                push_get(nsp, $urandom_range(1, 8));
                // broken prefix
                if (pick >= 6)
                    frm[UDP_PAY + $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
            end else begin
                push_noise($urandom_range(0, 12));
            end
        end else begin
            push_noise($urandom_range(0, 12));
        end

        pick = $urandom_range(0, 19);
        if (pick < 3)
            len = $urandom_range(1, frm.size());
        else if (pick < 5)
            len = frm.size() + $urandom_range(1, 40);
        else
            len = frm.size();
        send_frame(len);
    endtask

    initial begin
        int ph;
        int nfr;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames at reset configuration
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(0, 3);
        send_frame(1);                          // single-byte frame
        send_frame(TRANSPORT_START - 1);        // cut before transport header
        send_frame(int'(TRANSPORT_START));      // UDP header incomplete
        send_frame(UDP_PAY + 3);                // only "get" in payload
        send_frame(UDP_PAY + 4);                // bare "get ", ends in scan
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(3, 5);
        send_frame(frm.size());                 // extra spaces before key
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(10, 0);
        send_frame(frm.size());                 // spaces up to end of frame
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(0, 4);
        frm[UDP_PAY + 2] = CHAR_SPACE;
        send_frame(frm.size());                 // mangled prefix
        start_frame(PROTO_UDP, SERVICE_PORT_RST ^ 16'h0001);
        push_get(0, 4);
        send_frame(frm.size());                 // other port
        start_frame(PROTO_TCP, SERVICE_PORT_RST);
        send_frame(TCP_PAYLOAD_START + 3);      // TCP short of payload
        send_frame(TCP_PAYLOAD_START + 4);      // TCP invalidation
        start_frame(PROTO_TCP, SERVICE_PORT_RST ^ 16'h8000);
        send_frame(TCP_PAYLOAD_START + 6);
        start_frame(8'h00, SERVICE_PORT_RST);
        push_get(0, 2);
        send_frame(frm.size());                 // other protocol
        start_frame(8'hff, SERVICE_PORT_RST);
        send_frame(TCP_PAYLOAD_START + 8);
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(2, 6);
        send_frame(LONG_FRAME);                 // long frame, random tail after the key

        // Smallest limit: key right after prefix passes, one extra space does not
        wait_idle();
        write_reg(REG_MAX_KEY_OFFSET, 32'd5);
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(0, 3);
        send_frame(frm.size());
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(1, 3);
        send_frame(frm.size());
        start_frame(PROTO_UDP, SERVICE_PORT_RST);
        push_get(4, 3);
        send_frame(frm.size());

        // Random phases over several register settings
        for (ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(REG_SERVICE_PORT, 32'h0000_ffff);
                    write_reg(REG_MAX_KEY_OFFSET, 32'd2047);
                end
                1: begin
                    write_reg(REG_SERVICE_PORT, 32'h0000_0000);
                    write_reg(REG_MAX_KEY_OFFSET, 32'd5);
                end
                2: begin
                    write_reg(REG_SERVICE_PORT, $urandom_range(0, 65535));
                    write_reg(REG_MAX_KEY_OFFSET, $urandom_range(5, 40));
                    hold_req = 1'b1;            // back up the pipe behind a long stall
                end
                default: begin
                    write_reg(REG_SERVICE_PORT, {16'd0, SERVICE_PORT_RST});
                    write_reg(REG_MAX_KEY_OFFSET, {21'd0, MAX_KEY_OFFSET_RST});
                    quiet = 1'b1;               // full rate to the end
                end
            endcase
            phase_bytes = 0;
            nfr         = 0;
            while (phase_bytes < 120 || nfr < 2) begin
                send_random_frame();
                nfr++;
            end
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
